// ===== hw/rtl/bfdl_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfdl_pkg
// Types and constants shared by the brute-force discrete logarithm block.
// ----------------------------------------------------------------------------
package bfdl_pkg;

    localparam int OP_W    = 16;
    localparam int PROD_W  = 2 * OP_W;
    localparam int BCNT_W  = $clog2(PROD_W);

    typedef struct packed {
        logic [OP_W-1:0] target;
        logic [OP_W-1:0] base;
        logic [OP_W-1:0] modulus;
    } t_bfdl_req;

    typedef struct packed {
        logic [OP_W-1:0] exponent;
        logic            found;
    } t_bfdl_res;

    typedef struct packed {
        logic load;
        logic result;
        logic mul;
        logic step;
        logic finish;
    } t_bfdl_cmd;

    typedef struct packed {
        logic stop;
        logic red_last;
    } t_bfdl_sts;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_CHECK = 4'b0010,
        S_RED   = 4'b0100,
        S_SPARE = 4'b1000
    } t_bfdl_state;

endpackage

// ===== hw/rtl/bfdl_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfdl_ctrl
// Sequencer for the exponent search: compare, multiply, then reduce the
// product one bit per cycle back below the modulus.
// ----------------------------------------------------------------------------
module bfdl_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    output logic                o_done,
    input  bfdl_pkg::t_bfdl_sts i_sts,
    output bfdl_pkg::t_bfdl_cmd o_cmd
);
    import bfdl_pkg::*;

    t_bfdl_state r_state;
    t_bfdl_state n_state;
    logic        r_done;
    logic        n_done;

    always_comb begin
        n_state = r_state;
        n_done  = 1'b0;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_sts.stop) begin
                    o_cmd.result = 1'b1;
                    n_done       = 1'b1;
                    n_state      = S_IDLE;
                end else begin
                    o_cmd.mul = 1'b1;
                    n_state   = S_RED;
                end
            end
            S_RED: begin
                o_cmd.step = 1'b1;
                if (i_sts.red_last) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_CHECK;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
    end

    assign busy   = (r_state != S_IDLE);
    assign o_done = r_done;

endmodule

// ===== hw/rtl/bfdl_dpath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfdl_dpath
// Operand registers, power multiplier, bit-serial modular reduction and
// result register of the exponent search.
// ----------------------------------------------------------------------------
module bfdl_dpath (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  bfdl_pkg::t_bfdl_req i_req,
    input  bfdl_pkg::t_bfdl_cmd i_cmd,
    output bfdl_pkg::t_bfdl_sts o_sts,
    output bfdl_pkg::t_bfdl_res o_res
);
    import bfdl_pkg::*;

    logic [OP_W-1:0]   r_target;
    logic [OP_W-1:0]   r_base;
    logic [OP_W-1:0]   r_mod;
    logic [OP_W-1:0]   r_power;
    logic [OP_W-1:0]   r_count;
    logic [PROD_W-1:0] r_prod;
    logic [OP_W-1:0]   r_rem;
    logic [BCNT_W-1:0] r_bit_cnt;
    t_bfdl_res         r_res;

    logic              below;
    logic [OP_W:0]     trial;
    logic [OP_W:0]     n_trial;
    logic [OP_W-1:0]   n_rem;

    assign below = (r_count < r_mod);

    always_comb begin
        trial   = {r_rem, r_prod[PROD_W-1]};
        n_trial = trial;
        if (trial >= {1'b0, r_mod}) begin
            n_trial = trial - {1'b0, r_mod};
        end
        n_rem = n_trial[OP_W-1:0];
    end

    assign o_sts.stop     = !below || (r_power == r_target);
    assign o_sts.red_last = (r_bit_cnt == BCNT_W'(PROD_W - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit_cnt <= '0;
        end else if (i_cmd.mul) begin
            r_bit_cnt <= '0;
        end else if (i_cmd.step) begin
            r_bit_cnt <= r_bit_cnt + BCNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_target <= i_req.target;
            r_base   <= i_req.base;
            r_mod    <= i_req.modulus;
            r_power  <= i_req.base;
            r_count  <= OP_W'(1);
        end
        if (i_cmd.mul) begin
            r_prod <= PROD_W'(r_power) * PROD_W'(r_base);
            r_rem  <= '0;
        end
        if (i_cmd.step) begin
            r_prod <= {r_prod[PROD_W-2:0], 1'b0};
            r_rem  <= n_rem;
        end
        if (i_cmd.finish) begin
            r_power <= n_rem;
            r_count <= r_count + OP_W'(1);
        end
        if (i_cmd.result) begin
            r_res.exponent <= r_count;
            r_res.found    <= below;
        end
    end

    assign o_res = r_res;

`ifndef ASSERT_OFF
    a_rem_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.step |-> (r_rem < r_mod))
        else $error("partial remainder not below modulus");

    a_finish_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.finish |-> below)
        else $error("power update with count at the bound");
`endif

endmodule

// ===== hw/rtl/brute_force_discrete_log.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brute_force_discrete_log
// Finds the first exponent whose power of the base equals the target.
// ----------------------------------------------------------------------------
// A request beat (target, base, modulus) is taken on a rising edge with
// start high and busy low. busy stays high until the search ends. The
// result beat (exponent, found) is on o_res for exactly one cycle with
// o_done high; the receiver cannot stall it. busy is already low in that
// cycle, so the next request may be started there.
// The first power is the base as given. Each further exponent takes a
// compare state, which also launches the multiply, then the reduction state
// (one product bit per cycle through a shared compare-and-subtract).
// A modulus of zero or one gives exponent 1, found 0.
// Reset returns the sequencer to idle and drops any search in progress;
// no result is strobed for it.
// ----------------------------------------------------------------------------
module brute_force_discrete_log (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  bfdl_pkg::t_bfdl_req i_req,
    output logic                o_done,
    output bfdl_pkg::t_bfdl_res o_res
);
    import bfdl_pkg::*;

    t_bfdl_cmd cmd;
    t_bfdl_sts sts;

    bfdl_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .o_done  (o_done),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    bfdl_dpath u_dpath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .i_cmd   (cmd),
        .o_sts   (sts),
        .o_res   (o_res)
    );

`ifndef ASSERT_OFF
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result strobed while busy");

    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy && !o_done))
        else $error("accepted request did not start a search");

    a_exp_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_res.exponent != '0))
        else $error("zero exponent reported");
`endif

endmodule
